@@ rtl/core/rnp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnp_pkg
// Shared types, codes and helper functions of the ringtone note parser.
// ----------------------------------------------------------------------------
package rnp_pkg;

   // parse phase codes
   localparam logic [1:0] PH_NAME  = 2'd0;
   localparam logic [1:0] PH_CTRL  = 2'd1;
   localparam logic [1:0] PH_NOTES = 2'd2;

   // header key codes
   localparam logic [1:0] KEY_NONE = 2'd0;
   localparam logic [1:0] KEY_LEN  = 2'd1;
   localparam logic [1:0] KEY_OCT  = 2'd2;
   localparam logic [1:0] KEY_BPM  = 2'd3;

   // note step codes
   localparam logic [2:0] ST_LEAD  = 3'd0;
   localparam logic [2:0] ST_PITCH = 3'd1;
   localparam logic [2:0] ST_OCT   = 3'd2;
   localparam logic [2:0] ST_DOT   = 3'd3;
   localparam logic [2:0] ST_SKIP  = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_DEFAULT_LENGTH = 2'd0;
   localparam logic [1:0] CSR_BASE_OCTAVE    = 2'd1;
   localparam logic [1:0] CSR_DEFAULT_TEMPO  = 2'd2;

   // register reset values
   localparam logic [7:0] RST_DEFAULT_LENGTH = 8'd4;
   localparam logic [7:0] RST_BASE_OCTAVE    = 8'd5;
   localparam logic [9:0] RST_DEFAULT_TEMPO  = 10'd63;

   // characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_B = 8'h62;
   localparam logic [7:0] CH_LOW_D = 8'h64;
   localparam logic [7:0] CH_LOW_O = 8'h6F;
   localparam logic [7:0] CH_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   // saturation limits
   localparam logic [7:0] MAX_BYTE = 8'd255;
   localparam logic [9:0] MAX_BPM  = 10'd1023;

   typedef struct packed {
      logic [7:0] default_length;
      logic [7:0] base_octave;
      logic [9:0] default_tempo;
   } cfg_type;

   typedef struct packed {
      logic [7:0] note_length;
      logic [3:0] pitch_code;
      logic [7:0] note_octave;
      logic       dotted;
      logic [9:0] tempo_bpm;
      logic       last_note;
   } note_type;

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= CH_ZERO) && (ch <= CH_NINE);
   endfunction

   function automatic logic is_space(input logic [7:0] ch);
      return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
   endfunction

   // acc * 10 + digit, saturating at 255
   function automatic logic [7:0] sat_byte(input logic [7:0] acc, input logic [7:0] ch);
      logic [11:0] v;
      v = 12'(acc) * 12'd10 + 12'(ch - CH_ZERO);
      return (v > 12'(MAX_BYTE)) ? MAX_BYTE : v[7:0];
   endfunction

   // acc * 10 + digit, saturating at 1023
   function automatic logic [9:0] sat_bpm(input logic [9:0] acc, input logic [7:0] ch);
      logic [13:0] v;
      v = 14'(acc) * 14'd10 + 14'(ch - CH_ZERO);
      return (v > 14'(MAX_BPM)) ? MAX_BPM : v[9:0];
   endfunction

   function automatic logic [3:0] pitch_of(input logic [7:0] ch);
      logic [7:0] u;
      u = ch;
      if ((ch >= CH_LOW_A) && (ch <= CH_LOW_Z)) begin
         u = ch - CASE_OFFSET;
      end
      case (u)
         8'h43:   return 4'd1;  // C
         8'h44:   return 4'd3;  // D
         8'h45:   return 4'd5;  // E
         8'h46:   return 4'd6;  // F
         8'h47:   return 4'd8;  // G
         8'h41:   return 4'd10; // A
         8'h42:   return 4'd12; // B
         default: return 4'd0;  // pause, P and anything unknown
      endcase
   endfunction

   function automatic logic legal_length(input logic [7:0] a);
      return (a == 8'd1) || (a == 8'd2) || (a == 8'd4) || (a == 8'd8) ||
             (a == 8'd16) || (a == 8'd32);
   endfunction

   function automatic logic legal_octave(input logic [7:0] a);
      return (a >= 8'd4) && (a <= 8'd7);
   endfunction

endpackage

@@ rtl/core/rnp_csr_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnp_csr_regs
// Default length, octave and tempo registers behind the write port.
// ----------------------------------------------------------------------------
module rnp_csr_regs (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [1:0]       wr_index,
   input  logic [9:0]       wr_data,
   output rnp_pkg::cfg_type cfg
);

   rnp_pkg::cfg_type cfg_ff;
   rnp_pkg::cfg_type cfg_in;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            rnp_pkg::CSR_DEFAULT_LENGTH: cfg_in.default_length = wr_data[7:0];
            rnp_pkg::CSR_BASE_OCTAVE:    cfg_in.base_octave    = wr_data[7:0];
            rnp_pkg::CSR_DEFAULT_TEMPO:  cfg_in.default_tempo  = wr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_length <= rnp_pkg::RST_DEFAULT_LENGTH;
         cfg_ff.base_octave    <= rnp_pkg::RST_BASE_OCTAVE;
         cfg_ff.default_tempo  <= rnp_pkg::RST_DEFAULT_TEMPO;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/rnp_char_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnp_char_parser
// Per-character parse state and next-state logic; flags a finished note.
// ----------------------------------------------------------------------------
module rnp_char_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              char_accept,
   input  logic [7:0]        text_char,
   input  rnp_pkg::cfg_type  cfg,
   output logic              note_emit,
   output rnp_pkg::note_type note
);

   logic [1:0] phase_ff,  phase_in;
   logic [1:0] hkey_ff,   hkey_in;
   logic       kskip_ff,  kskip_in;
   logic [7:0] hlen_ff,   hlen_in;
   logic [7:0] hoct_ff,   hoct_in;
   logic [9:0] hbpm_ff,   hbpm_in;
   logic [2:0] step_ff,   step_in;
   logic [7:0] acc_ff,    acc_in;
   logic       dseen_ff,  dseen_in;
   logic [7:0] clen_ff,   clen_in;
   logic [3:0] cpitch_ff, cpitch_in;
   logic [7:0] coct_ff,   coct_in;
   logic       cdot_ff,   cdot_in;

   // next state for one accepted character
   always_comb begin
      logic [2:0] eff_step;
      logic       handled;
      phase_in  = phase_ff;
      hkey_in   = hkey_ff;
      kskip_in  = kskip_ff;
      hlen_in   = hlen_ff;
      hoct_in   = hoct_ff;
      hbpm_in   = hbpm_ff;
      step_in   = step_ff;
      acc_in    = acc_ff;
      dseen_in  = dseen_ff;
      clen_in   = clen_ff;
      cpitch_in = cpitch_ff;
      coct_in   = coct_ff;
      cdot_in   = cdot_ff;
      note_emit = 1'b0;
      note      = '0;
      eff_step  = step_ff;
      handled   = 1'b0;

      if (char_accept && !rnp_pkg::is_space(text_char)) begin
         if (phase_ff != rnp_pkg::PH_NOTES) begin
            // name and header sections
            if (text_char == rnp_pkg::CH_NUL) begin
               phase_in  = rnp_pkg::PH_NAME;
               hkey_in   = rnp_pkg::KEY_NONE;
               kskip_in  = 1'b0;
               hlen_in   = '0;
               hoct_in   = '0;
               hbpm_in   = '0;
               step_in   = rnp_pkg::ST_LEAD;
               acc_in    = '0;
               dseen_in  = 1'b0;
               clen_in   = '0;
               cpitch_in = '0;
               coct_in   = '0;
               cdot_in   = 1'b0;
            end else if (phase_ff == rnp_pkg::PH_CTRL) begin
               if (kskip_ff) begin
                  // separator after a key
                  kskip_in = 1'b0;
                  if (text_char == rnp_pkg::CH_COLON) begin
                     hkey_in  = rnp_pkg::KEY_NONE;
                     phase_in = rnp_pkg::PH_NOTES;
                     step_in  = rnp_pkg::ST_LEAD;
                     acc_in   = '0;
                     dseen_in = 1'b0;
                     clen_in  = '0;
                     cpitch_in = '0;
                     coct_in  = '0;
                     cdot_in  = 1'b0;
                  end
               end else begin
                  if (hkey_ff != rnp_pkg::KEY_NONE) begin
                     if (rnp_pkg::is_digit(text_char)) begin
                        handled = 1'b1;
                        case (hkey_ff)
                           rnp_pkg::KEY_LEN: hlen_in = rnp_pkg::sat_byte(hlen_ff, text_char);
                           rnp_pkg::KEY_OCT: hoct_in = rnp_pkg::sat_byte(hoct_ff, text_char);
                           default:          hbpm_in = rnp_pkg::sat_bpm(hbpm_ff, text_char);
                        endcase
                     end else begin
                        hkey_in = rnp_pkg::KEY_NONE;
                     end
                  end
                  if (!handled) begin
                     if (text_char == rnp_pkg::CH_LOW_D) begin
                        hkey_in  = rnp_pkg::KEY_LEN;
                        kskip_in = 1'b1;
                        hlen_in  = '0;
                     end else if (text_char == rnp_pkg::CH_LOW_O) begin
                        hkey_in  = rnp_pkg::KEY_OCT;
                        kskip_in = 1'b1;
                        hoct_in  = '0;
                     end else if (text_char == rnp_pkg::CH_LOW_B) begin
                        hkey_in  = rnp_pkg::KEY_BPM;
                        kskip_in = 1'b1;
                        hbpm_in  = '0;
                     end else if (text_char == rnp_pkg::CH_COLON) begin
                        phase_in  = rnp_pkg::PH_NOTES;
                        step_in   = rnp_pkg::ST_LEAD;
                        acc_in    = '0;
                        dseen_in  = 1'b0;
                        clen_in   = '0;
                        cpitch_in = '0;
                        coct_in   = '0;
                        cdot_in   = 1'b0;
                     end
                  end
               end
            end else if (text_char == rnp_pkg::CH_COLON) begin
               // end of the name
               phase_in = rnp_pkg::PH_CTRL;
               hkey_in  = rnp_pkg::KEY_NONE;
               kskip_in = 1'b0;
            end
         end else if ((text_char != rnp_pkg::CH_COMMA) && (text_char != rnp_pkg::CH_NUL)) begin
            // one character inside a note
            if (step_ff == rnp_pkg::ST_LEAD) begin
               if (rnp_pkg::is_digit(text_char)) begin
                  acc_in   = rnp_pkg::sat_byte(acc_ff, text_char);
                  dseen_in = 1'b1;
               end else begin
                  clen_in   = (dseen_ff && rnp_pkg::legal_length(acc_ff)) ? acc_ff : 8'd0;
                  acc_in    = '0;
                  dseen_in  = 1'b0;
                  cpitch_in = rnp_pkg::pitch_of(text_char);
                  step_in   = rnp_pkg::ST_PITCH;
               end
            end else begin
               if (step_ff == rnp_pkg::ST_PITCH) begin
                  eff_step = rnp_pkg::ST_OCT;
                  step_in  = rnp_pkg::ST_OCT;
                  if (text_char == rnp_pkg::CH_HASH) begin
                     cpitch_in = cpitch_ff + 4'd1;
                     handled   = 1'b1;
                  end
               end
               if (!handled &&
                   ((eff_step == rnp_pkg::ST_OCT) || (eff_step == rnp_pkg::ST_DOT))) begin
                  if (rnp_pkg::is_digit(text_char)) begin
                     acc_in   = rnp_pkg::sat_byte(acc_ff, text_char);
                     dseen_in = 1'b1;
                  end else begin
                     if (eff_step == rnp_pkg::ST_OCT) begin
                        if (dseen_ff) begin
                           coct_in = rnp_pkg::legal_octave(acc_ff) ? acc_ff : 8'd0;
                        end
                     end else if (dseen_ff && rnp_pkg::legal_octave(acc_ff)) begin
                        coct_in = acc_ff;
                     end
                     acc_in   = '0;
                     dseen_in = 1'b0;
                     if ((eff_step == rnp_pkg::ST_OCT) && (text_char == rnp_pkg::CH_DOT)) begin
                        cdot_in = 1'b1;
                        step_in = rnp_pkg::ST_DOT;
                     end else begin
                        step_in = rnp_pkg::ST_SKIP;
                     end
                  end
               end
            end
         end else begin
            // note delimiter: close the pending number and emit
            case (step_ff)
               rnp_pkg::ST_LEAD: begin
                  clen_in   = (dseen_ff && rnp_pkg::legal_length(acc_ff)) ? acc_ff : 8'd0;
                  cpitch_in = '0;
               end
               rnp_pkg::ST_OCT: begin
                  if (dseen_ff) begin
                     coct_in = rnp_pkg::legal_octave(acc_ff) ? acc_ff : 8'd0;
                  end
               end
               rnp_pkg::ST_DOT: begin
                  if (dseen_ff && rnp_pkg::legal_octave(acc_ff)) begin
                     coct_in = acc_ff;
                  end
               end
               default: begin
                  coct_in = coct_ff;
               end
            endcase
            note_emit = 1'b1;
            note.note_length = (clen_in != 8'd0) ? clen_in :
                               ((hlen_ff != 8'd0) ? hlen_ff : cfg.default_length);
            note.pitch_code  = cpitch_in;
            note.note_octave = (coct_in != 8'd0) ? coct_in :
                               ((hoct_ff != 8'd0) ? hoct_ff : cfg.base_octave);
            note.dotted      = cdot_ff;
            note.tempo_bpm   = (hbpm_ff != 10'd0) ? hbpm_ff : cfg.default_tempo;
            note.last_note   = (text_char == rnp_pkg::CH_NUL);
            // clear the note, and the whole tune on a null
            step_in   = rnp_pkg::ST_LEAD;
            acc_in    = '0;
            dseen_in  = 1'b0;
            clen_in   = '0;
            cpitch_in = '0;
            coct_in   = '0;
            cdot_in   = 1'b0;
            if (text_char == rnp_pkg::CH_NUL) begin
               phase_in = rnp_pkg::PH_NAME;
               hkey_in  = rnp_pkg::KEY_NONE;
               kskip_in = 1'b0;
               hlen_in  = '0;
               hoct_in  = '0;
               hbpm_in  = '0;
            end
         end
      end
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= rnp_pkg::PH_NAME;
         hkey_ff   <= rnp_pkg::KEY_NONE;
         kskip_ff  <= 1'b0;
         hlen_ff   <= '0;
         hoct_ff   <= '0;
         hbpm_ff   <= '0;
         step_ff   <= rnp_pkg::ST_LEAD;
         acc_ff    <= '0;
         dseen_ff  <= 1'b0;
         clen_ff   <= '0;
         cpitch_ff <= '0;
         coct_ff   <= '0;
         cdot_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         hkey_ff   <= hkey_in;
         kskip_ff  <= kskip_in;
         hlen_ff   <= hlen_in;
         hoct_ff   <= hoct_in;
         hbpm_ff   <= hbpm_in;
         step_ff   <= step_in;
         acc_ff    <= acc_in;
         dseen_ff  <= dseen_in;
         clen_ff   <= clen_in;
         cpitch_ff <= cpitch_in;
         coct_ff   <= coct_in;
         cdot_ff   <= cdot_in;
      end
   end

   // a key under way only exists inside the header
   a_key_in_header: assert property (@(posedge clock) disable iff (reset)
      (hkey_ff != rnp_pkg::KEY_NONE) |-> (phase_ff == rnp_pkg::PH_CTRL))
      else $error("header key active outside header section");

   // a pending separator skip always belongs to a key
   a_skip_has_key: assert property (@(posedge clock) disable iff (reset)
      kskip_ff |-> (hkey_ff != rnp_pkg::KEY_NONE))
      else $error("separator skip without a header key");

   // note decoding only advances in the tone list
   a_step_in_notes: assert property (@(posedge clock) disable iff (reset)
      (step_ff != rnp_pkg::ST_LEAD) |-> (phase_ff == rnp_pkg::PH_NOTES))
      else $error("note step advanced outside tone list");

endmodule

@@ rtl/core/rnp_rsp_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnp_rsp_reg
// Result register holding one finished note until the receiver takes it.
// ----------------------------------------------------------------------------
module rnp_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  rnp_pkg::note_type load_note,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output rnp_pkg::note_type rsp_note
);

   logic              valid_ff, valid_in;
   rnp_pkg::note_type note_ff,  note_in;

   // hold while stalled, otherwise take a new note or go empty
   always_comb begin
      valid_in = valid_ff;
      note_in  = note_ff;
      if (!valid_ff || !rsp_stall) begin
         valid_in = load;
         if (load) begin
            note_in = load_note;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      note_ff <= note_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_note  = note_ff;

   // a new note never arrives while the held one is stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |-> !load)
      else $error("note loaded while result register is stalled");

endmodule

@@ rtl/core/rtttl_note_parser_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtttl_note_parser_unit
// Ringtone text parser: one character in, one note record per ended note.
//
//   channel  direction  ports                         transfer when
//   req      in         req_valid/req_stall, text     valid && !stall
//   rsp      out        rsp_valid/rsp_stall, note     valid && !stall
//   csr      in         csr_valid/csr_ready, idx/data valid && ready
//
// One character is taken every cycle while req_stall is low; the parse state updates at that edge.
// A note ended by ',' or null appears on rsp in the cycle after its delimiter is taken.
// req_stall is high only while a held note is stalled on rsp.
// Synchronous reset returns the parser to the name section and the
// defaults to length 4, octave 5, tempo 63; csr_ready is always high.
// ----------------------------------------------------------------------------
module rtttl_note_parser_unit (
   input  logic       clock,
   input  logic       reset,
   // character input
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_char,
   // note output
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_note_length,
   output logic [3:0] rsp_pitch_code,
   output logic [7:0] rsp_note_octave,
   output logic       rsp_dotted,
   output logic [9:0] rsp_tempo_bpm,
   output logic       rsp_last_note,
   // register writes
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [9:0] csr_wdata
);

   rnp_pkg::cfg_type  cfg;
   rnp_pkg::note_type parsed_note;
   rnp_pkg::note_type held_note;
   logic              note_emit;
   logic              char_accept;

   // input transfer
   assign req_stall   = rsp_valid && rsp_stall;
   assign char_accept = req_valid && !req_stall;
   assign csr_ready   = 1'b1;

   rnp_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   rnp_char_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .char_accept (char_accept),
      .text_char   (req_text_char),
      .cfg         (cfg),
      .note_emit   (note_emit),
      .note        (parsed_note)
   );

   rnp_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (note_emit),
      .load_note (parsed_note),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_note  (held_note)
   );

   // result fields
   assign rsp_note_length = held_note.note_length;
   assign rsp_pitch_code  = held_note.pitch_code;
   assign rsp_note_octave = held_note.note_octave;
   assign rsp_dotted      = held_note.dotted;
   assign rsp_tempo_bpm   = held_note.tempo_bpm;
   assign rsp_last_note   = held_note.last_note;

endmodule
